@@ design/qrs_pkg.sv @@
package qrs_pkg;

    localparam int FIELD_W = 32;
    localparam int DISC_W  = 64;

    typedef enum logic [2:0] {
        CK_DEGEN    = 3'd0,
        CK_LINEAR   = 3'd1,
        CK_TWO_REAL = 3'd2,
        CK_DOUBLE   = 3'd3,
        CK_COMPLEX  = 3'd4
    } t_case_kind;

endpackage

@@ design/qrs_coef_if.sv @@
interface qrs_coef_if import qrs_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] coef_quad;
    logic signed [FIELD_W-1:0] coef_lin;
    logic signed [FIELD_W-1:0] coef_const;

    modport source (output valid, coef_quad, coef_lin, coef_const, input ready);
    modport sink   (input valid, coef_quad, coef_lin, coef_const, output ready);
endinterface

@@ design/qrs_root_if.sv @@
interface qrs_root_if import qrs_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [2:0]                case_kind;
    logic signed [FIELD_W-1:0] root_first;
    logic signed [FIELD_W-1:0] root_second;
    logic signed [DISC_W-1:0]  discriminant;
    logic                      overflow_flag;

    modport source (output valid, case_kind, root_first, root_second, discriminant,
                    overflow_flag, input ready);
    modport sink   (input valid, case_kind, root_first, root_second, discriminant,
                    overflow_flag, output ready);
endinterface

@@ design/quadratic_root_solver.sv @@
// Solves a*x^2 + b*x + c = 0 for one set of signed fixed-point coefficients per item and
// returns the case, two roots, the discriminant b*b - 4ac and a saturation flag. A new
// item is taken every cycle unless the output stalls. The pipeline holds a bit-per-stage square
// root (COEF_WIDTH + 1 stages) and two bit-per-stage dividers. The whole pipeline
// holds while a finished item waits at the output register. Square roots round down,
// quotients truncate toward zero, and roots saturate to the COEF_WIDTH-bit range.
module quadratic_root_solver import qrs_pkg::*; #(
    parameter int FRAC_BITS  = 16,
    parameter int COEF_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qrs_coef_if.sink  i_coef,
    qrs_root_if.source o_root
);

    localparam int W   = COEF_WIDTH;
    localparam int DW  = 2 * W + 2;
    localparam int EW  = (DW > 65) ? DW : 65;
    localparam int SQ  = W + 1;
    localparam int RW  = W + 3;
    localparam int PW  = W + 3;
    localparam int NW  = W + 2;
    localparam int DNW = W + 1;
    localparam int QW  = NW + FRAC_BITS;

    localparam logic [EW-1:0] DPOS = EW'({1'b0, {(DISC_W-1){1'b1}}});
    localparam logic [EW-1:0] DNEG = EW'({1'b1, {(DISC_W-1){1'b0}}});
    localparam logic [QW-1:0] MAXP = QW'({(W-1){1'b1}});
    localparam logic [QW-1:0] MAXN = MAXP + QW'(1);

    typedef struct packed {
        t_case_kind          kind;
        logic                a_neg;
        logic [W-1:0]        a_mag;
        logic signed [W-1:0] b;
        logic signed [W-1:0] c;
        logic [DISC_W-1:0]   disc;
        logic                ovf_d;
    } t_side1;

    typedef struct packed {
        t_case_kind        kind;
        logic [DISC_W-1:0] disc;
        logic              ovf_d;
        logic              neg1;
        logic              neg2;
    } t_side2;

    function automatic logic [W-1:0] mag(input logic [W-1:0] x);
        mag = x[W-1] ? (~x + W'(1)) : x;
    endfunction

    // {flag, value}
    function automatic logic [W:0] sat_root(input logic [QW-1:0] q, input logic neg);
        logic [QW-1:0] nq;
        nq = ~q + QW'(1);
        if (neg) begin
            if (q > MAXN) sat_root = {1'b1, MAXN[W-1:0]};
            else          sat_root = {1'b0, nq[W-1:0]};
        end else begin
            if (q > MAXP) sat_root = {1'b1, MAXP[W-1:0]};
            else          sat_root = {1'b0, q[W-1:0]};
        end
    endfunction

    logic en;
    logic r_out_v;

    assign en           = !r_out_v || o_root.ready;
    assign i_coef.ready = en;

    // stage 1: coefficients
    logic                r1_v;
    logic signed [W-1:0] r1_a, r1_b, r1_c;

    // stage 2: products
    logic                r2_v;
    logic [2*W-1:0]      r2_b2, r2_m;
    logic                r2_a_neg, r2_c_neg, r2_a_zero, r2_b_zero;
    logic [W-1:0]        r2_a_mag;
    logic signed [W-1:0] r2_b, r2_c;

    // stage 3: discriminant magnitude
    logic                r3_v;
    logic [DW-1:0]       r3_d;
    logic                r3_dneg, r3_a_zero, r3_b_zero, r3_a_neg;
    logic [W-1:0]        r3_a_mag;
    logic signed [W-1:0] r3_b, r3_c;

    logic [2*W-1:0] n_b2, n_m;
    logic [W-1:0]   mag_a, mag_b, mag_c;
    logic [DW-1:0]  n_d, b2e, m4;
    logic           n_dneg, acneg;

    assign mag_a = mag(r1_a);
    assign mag_b = mag(r1_b);
    assign mag_c = mag(r1_c);
    assign n_b2  = mag_b * mag_b;
    assign n_m   = mag_a * mag_c;

    assign b2e   = DW'(r2_b2);
    assign m4    = {r2_m, 2'b00};
    assign acneg = (r2_m != '0) && (r2_a_neg != r2_c_neg);

    always_comb begin
        if (acneg) begin
            n_d    = b2e + m4;
            n_dneg = 1'b0;
        end else if (b2e >= m4) begin
            n_d    = b2e - m4;
            n_dneg = 1'b0;
        end else begin
            n_d    = m4 - b2e;
            n_dneg = 1'b1;
        end
    end

    // stage 4: case, saturated discriminant, root entry
    t_side1         n_sd1;
    logic [EW-1:0]  dext;

    assign dext = EW'(r3_d);

    always_comb begin
        n_sd1.a_neg = r3_a_neg;
        n_sd1.a_mag = r3_a_mag;
        n_sd1.b     = r3_b;
        n_sd1.c     = r3_c;
        if (r3_a_zero) begin
            n_sd1.kind  = r3_b_zero ? CK_DEGEN : CK_LINEAR;
            n_sd1.disc  = '0;
            n_sd1.ovf_d = 1'b0;
        end else begin
            if (r3_d == '0)   n_sd1.kind = CK_DOUBLE;
            else if (r3_dneg) n_sd1.kind = CK_COMPLEX;
            else              n_sd1.kind = CK_TWO_REAL;
            if (r3_dneg) begin
                n_sd1.ovf_d = dext > DNEG;
                n_sd1.disc  = n_sd1.ovf_d ? DNEG[DISC_W-1:0] : (~dext[DISC_W-1:0] + 1'b1);
            end else begin
                n_sd1.ovf_d = dext > DPOS;
                n_sd1.disc  = n_sd1.ovf_d ? DPOS[DISC_W-1:0] : dext[DISC_W-1:0];
            end
        end
    end

    // square root, two radicand bits per stage
    logic [SQ:0]   r_sq_v;
    logic [RW-1:0] r_sq_rem  [0:SQ];
    logic [W:0]    r_sq_root [0:SQ];
    logic [DW-1:0] r_sq_dsh  [0:SQ];
    t_side1        r_sd1     [0:SQ];

    logic [RW-1:0] n_sq_rem  [0:SQ-1];
    logic [W:0]    n_sq_root [0:SQ-1];

    always_comb begin
        logic [RW+1:0] cur;
        logic [RW+1:0] trial;
        for (int k = 0; k < SQ; k++) begin
            cur   = {r_sq_rem[k], r_sq_dsh[k][DW-1:DW-2]};
            trial = (RW+2)'({r_sq_root[k], 2'b01});
            if (cur >= trial) begin
                n_sq_rem[k]  = RW'(cur - trial);
                n_sq_root[k] = {r_sq_root[k][W-1:0], 1'b1};
            end else begin
                n_sq_rem[k]  = cur[RW-1:0];
                n_sq_root[k] = {r_sq_root[k][W-1:0], 1'b0};
            end
        end
    end

    // numerators and denominator for the dividers
    t_side1               sd;
    t_side2               n_sd2;
    logic [W:0]           root_s;
    logic signed [PW-1:0] sb, sc, ss, n1, n2;
    logic [PW-1:0]        n1_abs, n2_abs;
    logic [NW-1:0]        num1, num2;
    logic [DNW-1:0]       den;
    logic                 den_neg;

    assign sd     = r_sd1[SQ];
    assign root_s = r_sq_root[SQ];

    always_comb begin
        sb = PW'(signed'(sd.b));
        sc = PW'(signed'(sd.c));
        ss = signed'(PW'(root_s));
        case (sd.kind)
            CK_LINEAR: begin
                n1 = -sc;
                n2 = '0;
            end
            CK_TWO_REAL: begin
                n1 = -sb - ss;
                n2 = -sb + ss;
            end
            CK_COMPLEX: begin
                n1 = -sb;
                n2 = ss;
            end
            default: begin
                n1 = -sb;
                n2 = '0;
            end
        endcase
        n1_abs  = n1[PW-1] ? PW'(-n1) : PW'(n1);
        n2_abs  = n2[PW-1] ? PW'(-n2) : PW'(n2);
        num1    = n1_abs[NW-1:0];
        num2    = n2_abs[NW-1:0];
        if (sd.kind == CK_LINEAR) begin
            den     = DNW'(mag(sd.b));
            den_neg = sd.b[W-1];
        end else begin
            den     = {sd.a_mag, 1'b0};
            den_neg = sd.a_neg;
        end
        n_sd2.kind  = sd.kind;
        n_sd2.disc  = sd.disc;
        n_sd2.ovf_d = sd.ovf_d;
        n_sd2.neg1  = n1[PW-1] ^ den_neg;
        n_sd2.neg2  = (sd.kind == CK_TWO_REAL) ? (n2[PW-1] ^ sd.a_neg) : 1'b0;
    end

    logic [QW-1:0] q1, q2;

    qrs_div #(.NUM_W(NW), .DEN_W(DNW), .FRAC(FRAC_BITS)) u_div1 (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (num1),
        .i_den  (den),
        .o_quot (q1)
    );

    qrs_div #(.NUM_W(NW), .DEN_W(DNW), .FRAC(FRAC_BITS)) u_div2 (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (num2),
        .i_den  (den),
        .o_quot (q2)
    );

    logic [QW:0] r_dv_v;
    t_side2      r_sd2 [0:QW];

    // output stage
    t_side2            fs;
    logic [W:0]        s1, s2;
    t_case_kind        n_kind;
    logic [W-1:0]      n_r1, n_r2;
    logic [DISC_W-1:0] n_disc;
    logic              n_ovf;

    assign fs = r_sd2[QW];
    assign s1 = sat_root(q1, fs.neg1);
    assign s2 = sat_root(q2, fs.neg2);

    always_comb begin
        n_kind = fs.kind;
        n_disc = fs.disc;
        n_r1   = s1[W-1:0];
        n_r2   = s2[W-1:0];
        n_ovf  = fs.ovf_d | s1[W] | s2[W];
        case (fs.kind)
            CK_DEGEN: begin
                n_r1   = '0;
                n_r2   = '0;
                n_disc = '0;
                n_ovf  = 1'b0;
            end
            CK_LINEAR: begin
                n_r2  = '0;
                n_ovf = s1[W];
            end
            CK_DOUBLE: begin
                n_r2  = s1[W-1:0];
                n_ovf = fs.ovf_d | s1[W];
            end
            default: ;
        endcase
    end

    logic [2:0]        r_kind;
    logic [W-1:0]      r_r1, r_r2;
    logic [DISC_W-1:0] r_disc;
    logic              r_ovf;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r_sq_v  <= '0;
            r_dv_v  <= '0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r1_v    <= i_coef.valid;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r_sq_v  <= {r_sq_v[SQ-1:0], r3_v};
            r_dv_v  <= {r_dv_v[QW-1:0], r_sq_v[SQ]};
            r_out_v <= r_dv_v[QW];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_a <= i_coef.coef_quad[W-1:0];
            r1_b <= i_coef.coef_lin[W-1:0];
            r1_c <= i_coef.coef_const[W-1:0];

            r2_b2     <= n_b2;
            r2_m      <= n_m;
            r2_a_neg  <= r1_a[W-1];
            r2_c_neg  <= r1_c[W-1];
            r2_a_zero <= (r1_a == '0);
            r2_b_zero <= (r1_b == '0);
            r2_a_mag  <= mag_a;
            r2_b      <= r1_b;
            r2_c      <= r1_c;

            r3_d      <= n_d;
            r3_dneg   <= n_dneg;
            r3_a_zero <= r2_a_zero;
            r3_b_zero <= r2_b_zero;
            r3_a_neg  <= r2_a_neg;
            r3_a_mag  <= r2_a_mag;
            r3_b      <= r2_b;
            r3_c      <= r2_c;

            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_dsh[0]  <= r3_d;
            r_sd1[0]     <= n_sd1;
            for (int k = 0; k < SQ; k++) begin
                r_sq_rem[k+1]  <= n_sq_rem[k];
                r_sq_root[k+1] <= n_sq_root[k];
                r_sq_dsh[k+1]  <= {r_sq_dsh[k][DW-3:0], 2'b00};
                r_sd1[k+1]     <= r_sd1[k];
            end

            r_sd2[0] <= n_sd2;
            for (int k = 0; k < QW; k++) begin
                r_sd2[k+1] <= r_sd2[k];
            end

            r_kind <= n_kind;
            r_r1   <= n_r1;
            r_r2   <= n_r2;
            r_disc <= n_disc;
            r_ovf  <= n_ovf;
        end
    end

    assign o_root.valid         = r_out_v;
    assign o_root.case_kind     = r_kind;
    assign o_root.root_first    = FIELD_W'(signed'(r_r1));
    assign o_root.root_second   = FIELD_W'(signed'(r_r2));
    assign o_root.discriminant  = r_disc;
    assign o_root.overflow_flag = r_ovf;

`ifndef SYNTHESIS
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_root.valid && o_root.case_kind == CK_DEGEN) |->
        (o_root.root_first == 0 && o_root.root_second == 0 &&
         o_root.discriminant == 0 && !o_root.overflow_flag))
        else $error("degenerate item carries nonzero fields");

    a_linear_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_root.valid && o_root.case_kind == CK_LINEAR) |->
        (o_root.root_second == 0 && o_root.discriminant == 0))
        else $error("linear item has second root or discriminant");

    a_double_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_root.valid && o_root.case_kind == CK_DOUBLE) |->
        (o_root.root_first == o_root.root_second && o_root.discriminant == 0))
        else $error("double root fields disagree");

    a_complex_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_root.valid && o_root.case_kind == CK_COMPLEX) |->
        (!o_root.root_second[FIELD_W-1] && o_root.discriminant[DISC_W-1]))
        else $error("complex item has negative magnitude or nonnegative discriminant");
`endif

endmodule

@@ design/qrs_div.sv @@
module qrs_div #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 33,
    parameter int FRAC  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [NUM_W-1:0]      i_num,
    input  logic [DEN_W-1:0]      i_den,
    output logic [NUM_W+FRAC-1:0] o_quot
);

    localparam int QW = NUM_W + FRAC;

    logic [DEN_W-1:0] r_rem  [0:QW];
    logic [QW-1:0]    r_quot [0:QW];
    logic [QW-1:0]    r_nsh  [0:QW];
    logic [DEN_W-1:0] r_den  [0:QW];

    logic [DEN_W-1:0] n_rem  [0:QW-1];
    logic [QW-1:0]    n_quot [0:QW-1];

    // one quotient bit per stage, restoring
    always_comb begin
        logic [DEN_W:0] t;
        for (int k = 0; k < QW; k++) begin
            t = {r_rem[k], r_nsh[k][QW-1]};
            if (t >= {1'b0, r_den[k]}) begin
                n_rem[k]  = DEN_W'(t - {1'b0, r_den[k]});
                n_quot[k] = {r_quot[k][QW-2:0], 1'b1};
            end else begin
                n_rem[k]  = t[DEN_W-1:0];
                n_quot[k] = {r_quot[k][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_quot[0] <= '0;
            r_nsh[0]  <= QW'(i_num) << FRAC;
            r_den[0]  <= i_den;
            for (int k = 0; k < QW; k++) begin
                r_rem[k+1]  <= n_rem[k];
                r_quot[k+1] <= n_quot[k];
                r_nsh[k+1]  <= {r_nsh[k][QW-2:0], 1'b0};
                r_den[k+1]  <= r_den[k];
            end
        end
    end

    assign o_quot = r_quot[QW];

endmodule
